>>> rtl/core/rthsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared types, constants and the divider step for the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rthsv_pkg;

   localparam int CHAN_W = 8;
   localparam int OUT_W  = 15;
   localparam int QUO_W  = 16;
   localparam int NUM_W  = QUO_W + CHAN_W;

   localparam int RTHSV_DIV_STEPS = 4;

   localparam int unsigned HUE_SIXTH_Q6 = 3840;
   localparam int unsigned HUE_FULL_Q6  = 23040;
   localparam int unsigned PCT_Q8       = 25600;
   localparam int unsigned VAL_PCT      = 100;
   // floor(v/255) = (max * VAL_RECIP) >> VAL_SHIFT, with v = max * 100
   localparam int unsigned VAL_RECIP    = 3289700;
   localparam int          VAL_SHIFT    = 23;
   localparam int          VAL_PROD_W   = 30;

   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rthsv_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] hue_deg_q6;
      logic [OUT_W-1:0] sat_pct_q8;
      logic [OUT_W-1:0] val_pct_q8;
      logic             achromatic;
   } rthsv_rsp_type;

   typedef struct packed {
      logic [OUT_W-1:0] hue_base;
      logic             hue_neg;
      logic             gray;
      logic             sat_zero;
      logic [OUT_W-1:0] val;
   } rthsv_side_type;

   typedef struct packed {
      logic [NUM_W-1:0]  hue_num;
      logic [NUM_W-1:0]  sat_num;
      logic [CHAN_W-1:0] delta;
      logic [CHAN_W-1:0] mx;
      rthsv_side_type    side;
   } rthsv_num_type;

   typedef struct packed {
      logic [CHAN_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
   } rthsv_lane_type;

   typedef struct packed {
      rthsv_lane_type    hue;
      rthsv_lane_type    sat;
      logic [CHAN_W-1:0] delta;
      logic [CHAN_W-1:0] mx;
      rthsv_side_type    side;
   } rthsv_div_type;

   typedef struct packed {
      logic [QUO_W-1:0] hue_q;
      logic [QUO_W-1:0] sat_q;
      rthsv_side_type   side;
   } rthsv_quo_type;

   // one restoring division step: shift in next dividend bit, try subtract
   function automatic rthsv_lane_type div_step(input rthsv_lane_type lane,
                                               input logic [CHAN_W-1:0] d);
      rthsv_lane_type    res;
      logic [CHAN_W:0]   t;
      logic [CHAN_W:0]   diff;
      logic              ge;
      t    = {lane.rem, lane.quo[QUO_W-1]};
      diff = t - {1'b0, d};
      ge   = (t >= {1'b0, d});
      res.rem = ge ? diff[CHAN_W-1:0] : t[CHAN_W-1:0];
      res.quo = {lane.quo[QUO_W-2:0], ge};
      return res;
   endfunction

endpackage

>>> rtl/core/rthsv_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two stages: max/min select, then delta, hue difference, numerators and value.
// ----------------------------------------------------------------------------
module rthsv_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rthsv_pkg::rthsv_req_type req_data,
   output logic                   num_valid,
   input  logic                   num_ready,
   output rthsv_pkg::rthsv_num_type num_data
);
   import rthsv_pkg::*;

   logic              s1_valid_ff;
   logic [CHAN_W-1:0] s1_mx_ff, s1_mn_ff, s1_pa_ff, s1_pb_ff;
   logic [1:0]        s1_sel_ff;
   logic [CHAN_W-1:0] s1_mx_in, s1_mn_in, s1_pa_in, s1_pb_in;
   logic [1:0]        s1_sel_in;
   logic              s1_ready, s2_ready;

   logic              s2_valid_ff;
   rthsv_num_type     s2_ff, s2_in;

   logic [CHAN_W-1:0]     delta, adiff;
   logic                  neg;
   logic [VAL_PROD_W-1:0] val_prod;

   assign s2_ready  = !s2_valid_ff || num_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      if (req_data.red >= req_data.green && req_data.red >= req_data.blue) begin
         s1_sel_in = SEL_RED;
         s1_mx_in  = req_data.red;
         s1_pa_in  = req_data.green;
         s1_pb_in  = req_data.blue;
      end else if (req_data.green >= req_data.blue) begin
         s1_sel_in = SEL_GREEN;
         s1_mx_in  = req_data.green;
         s1_pa_in  = req_data.blue;
         s1_pb_in  = req_data.red;
      end else begin
         s1_sel_in = SEL_BLUE;
         s1_mx_in  = req_data.blue;
         s1_pa_in  = req_data.red;
         s1_pb_in  = req_data.green;
      end
      s1_mn_in = req_data.red;
      if (req_data.green < s1_mn_in) s1_mn_in = req_data.green;
      if (req_data.blue < s1_mn_in) s1_mn_in = req_data.blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_ready && req_valid) begin
         s1_mx_ff  <= s1_mx_in;
         s1_mn_ff  <= s1_mn_in;
         s1_pa_ff  <= s1_pa_in;
         s1_pb_ff  <= s1_pb_in;
         s1_sel_ff <= s1_sel_in;
      end
   end

   always_comb begin
      delta    = s1_mx_ff - s1_mn_ff;
      neg      = (s1_pa_ff < s1_pb_ff);
      adiff    = neg ? (s1_pb_ff - s1_pa_ff) : (s1_pa_ff - s1_pb_ff);
      val_prod = VAL_PROD_W'(s1_mx_ff) * VAL_PROD_W'(VAL_RECIP);

      s2_in.hue_num = NUM_W'(adiff) * NUM_W'(HUE_SIXTH_Q6);
      s2_in.sat_num = NUM_W'(delta) * NUM_W'(PCT_Q8);
      s2_in.delta   = delta;
      s2_in.mx      = s1_mx_ff;
      s2_in.side.hue_neg  = neg;
      s2_in.side.gray     = (delta == '0);
      s2_in.side.sat_zero = (s1_mx_ff == '0);
      s2_in.side.val      = OUT_W'(s1_mx_ff) * OUT_W'(VAL_PCT)
                            + OUT_W'(val_prod >> VAL_SHIFT);
      case (s1_sel_ff)
         SEL_RED:   s2_in.side.hue_base = neg ? OUT_W'(HUE_FULL_Q6) : '0;
         SEL_GREEN: s2_in.side.hue_base = OUT_W'(2 * HUE_SIXTH_Q6);
         SEL_BLUE:  s2_in.side.hue_base = OUT_W'(4 * HUE_SIXTH_Q6);
         default:   s2_in.side.hue_base = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign num_valid = s2_valid_ff;
   assign num_data  = s2_ff;

endmodule

>>> rtl/core/rthsv_div.sv
// ----------------------------------------------------------------------------
// RGB to HSV divider pipeline
// Two restoring dividers side by side (hue fraction, saturation), several
// quotient bits per stage, sideband carried along.
// ----------------------------------------------------------------------------
module rthsv_div #(
   parameter int STEPS = rthsv_pkg::RTHSV_DIV_STEPS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    num_valid,
   output logic                    num_ready,
   input  rthsv_pkg::rthsv_num_type num_data,
   output logic                    quo_valid,
   input  logic                    quo_ready,
   output rthsv_pkg::rthsv_quo_type quo_data
);
   import rthsv_pkg::*;

   localparam int NSTAGE = QUO_W / STEPS;

   rthsv_div_type head;
   rthsv_div_type src      [NSTAGE];
   rthsv_div_type stage_in [NSTAGE];
   rthsv_div_type stage_ff [NSTAGE];
   logic          src_valid[NSTAGE];
   logic          valid_ff [NSTAGE];
   logic          rdy      [NSTAGE];
   logic          down_rdy [NSTAGE];

   always_comb begin
      head.hue.rem = num_data.hue_num[NUM_W-1:QUO_W];
      head.hue.quo = num_data.hue_num[QUO_W-1:0];
      head.sat.rem = num_data.sat_num[NUM_W-1:QUO_W];
      head.sat.quo = num_data.sat_num[QUO_W-1:0];
      head.delta   = num_data.delta;
      head.mx      = num_data.mx;
      head.side    = num_data.side;
   end

   for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
      if (j == 0) begin : g_first
         assign src[j]       = head;
         assign src_valid[j] = num_valid;
      end else begin : g_next
         assign src[j]       = stage_ff[j-1];
         assign src_valid[j] = valid_ff[j-1];
      end

      if (j == NSTAGE - 1) begin : g_last
         assign down_rdy[j] = quo_ready;
      end else begin : g_mid
         assign down_rdy[j] = rdy[j+1];
      end

      assign rdy[j] = !valid_ff[j] || down_rdy[j];

      always_comb begin
         rthsv_div_type cur;
         cur = src[j];
         for (int k = 0; k < STEPS; k++) begin
            cur.hue = div_step(cur.hue, cur.delta);
            cur.sat = div_step(cur.sat, cur.mx);
         end
         stage_in[j] = cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            valid_ff[j] <= src_valid[j];
         end
         if (rdy[j] && src_valid[j]) begin
            stage_ff[j] <= stage_in[j];
         end
      end
   end

   assign num_ready      = rdy[0];
   assign quo_valid      = valid_ff[NSTAGE-1];
   assign quo_data.hue_q = stage_ff[NSTAGE-1].hue.quo;
   assign quo_data.sat_q = stage_ff[NSTAGE-1].sat.quo;
   assign quo_data.side  = stage_ff[NSTAGE-1].side;

endmodule

>>> rtl/core/rthsv_out.sv
// ----------------------------------------------------------------------------
// RGB to HSV output stage
// Applies hue sign and base, gray and black overrides; output register.
// ----------------------------------------------------------------------------
module rthsv_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    quo_valid,
   output logic                    quo_ready,
   input  rthsv_pkg::rthsv_quo_type quo_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rthsv_pkg::rthsv_rsp_type rsp_data
);
   import rthsv_pkg::*;

   logic             rsp_valid_ff;
   rthsv_rsp_type    rsp_ff, rsp_in;
   logic [QUO_W-1:0] hue_sum;

   assign quo_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      hue_sum = quo_data.side.hue_neg
              ? QUO_W'(quo_data.side.hue_base) - quo_data.hue_q
              : QUO_W'(quo_data.side.hue_base) + quo_data.hue_q;
      rsp_in.hue_deg_q6 = quo_data.side.gray ? '0 : hue_sum[OUT_W-1:0];
      rsp_in.sat_pct_q8 = quo_data.side.sat_zero ? '0 : quo_data.sat_q[OUT_W-1:0];
      rsp_in.val_pct_q8 = quo_data.side.val;
      rsp_in.achromatic = quo_data.side.gray;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (quo_ready) begin
         rsp_valid_ff <= quo_valid;
      end
      if (quo_ready && quo_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/rgb_to_hsv_convert_top.sv
// A request passes the front end, divider and output registers to the response.
// Throughput: one pixel per cycle, every stage taking one, while rsp_ready holds.
// A stalled response holds its stage; upstream stages keep filling bubbles.
// Reset clears all valid bits; data registers are not reset and need no clearing.
// ----------------------------------------------------------------------------
// RGB to HSV conversion top
// Pixel in, hue/saturation/value in fixed point out, fully pipelined.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_top #(
   parameter int STEPS_PER_STAGE = rthsv_pkg::RTHSV_DIV_STEPS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rthsv_pkg::rthsv_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rthsv_pkg::rthsv_rsp_type rsp_data
);
   import rthsv_pkg::*;

   logic          num_valid, num_ready;
   rthsv_num_type num_data;
   logic          quo_valid, quo_ready;
   rthsv_quo_type quo_data;

   rthsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .num_valid (num_valid),
      .num_ready (num_ready),
      .num_data  (num_data)
   );

   rthsv_div #(
      .STEPS (STEPS_PER_STAGE)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .num_valid (num_valid),
      .num_ready (num_ready),
      .num_data  (num_data),
      .quo_valid (quo_valid),
      .quo_ready (quo_ready),
      .quo_data  (quo_data)
   );

   rthsv_out u_out (
      .clock     (clock),
      .reset     (reset),
      .quo_valid (quo_valid),
      .quo_ready (quo_ready),
      .quo_data  (quo_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/rthsv_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSV port checker
// Watches the top-level ports for response stability, reset behaviour, ranges and gray rules.
// ----------------------------------------------------------------------------
module rthsv_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input rthsv_pkg::rthsv_rsp_type rsp_data
);
   import rthsv_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response transaction changed");

   a_post_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hue_deg_q6 < OUT_W'(HUE_FULL_Q6)
                 && rsp_data.sat_pct_q8 <= OUT_W'(PCT_Q8)
                 && rsp_data.val_pct_q8 <= OUT_W'(PCT_Q8))
      else $error("response field out of range");

   a_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.achromatic |->
         rsp_data.hue_deg_q6 == '0 && rsp_data.sat_pct_q8 == '0)
      else $error("gray pixel with nonzero hue or saturation");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_seen |=> !rsp_valid)
      else $error("response without any request");

endmodule

bind rgb_to_hsv_convert_top rthsv_checker u_rthsv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
